>>> hw/rtl/fsf_pkg.sv
// fsf_pkg: shared types, constants and status codes of the FIX stream framer.
// Used by every module in hw/rtl; depends on nothing.
package fsf_pkg;

   localparam int MAX_LENGTH_DIGITS = 10;
   localparam int TRAILER_BYTES     = 7;
   localparam int BEGIN_LEN         = 10;
   localparam int LENGTH_TAG_LEN    = 2;
   localparam int SUM_TAG_LEN       = 3;

   // Smallest complete message: begin string, "9=", one digit, SOH, trailer.
   localparam int MIN_FRAME_BYTES = BEGIN_LEN + LENGTH_TAG_LEN + 2 + TRAILER_BYTES;

   // Position counter covers the longest of the fixed-length sections.
   localparam int POS_MAX = (MAX_LENGTH_DIGITS > BEGIN_LEN) ? MAX_LENGTH_DIGITS : BEGIN_LEN;
   localparam int POS_W   = $clog2(POS_MAX + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [31:0] MAX_BODY_RESET = 32'd65536;

   localparam logic [7:0] SOH_BYTE   = 8'h01;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_EQUAL = 8'h3d;

   // Result status codes.
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_BEGIN  = 3'd1;
   localparam logic [2:0] ST_NO_LEN_TAG = 3'd2;
   localparam logic [2:0] ST_BAD_DIGITS = 3'd3;
   localparam logic [2:0] ST_TOO_LARGE  = 3'd4;
   localparam logic [2:0] ST_EMPTY_LEN  = 3'd5;
   localparam logic [2:0] ST_NO_SUM     = 3'd6;

   // Classification of one stream byte, produced by the front end.
   typedef struct packed {
      logic [BEGIN_LEN-1:0]      begin_hit;
      logic [LENGTH_TAG_LEN-1:0] len_tag_hit;
      logic [SUM_TAG_LEN-1:0]    sum_tag_hit;
      logic                      is_soh;
      logic                      is_digit;
      logic [3:0]                digit;
   } class_type;

   // Expected byte at each place of "8=FIX.4.4" SOH.
   function automatic logic [7:0] begin_byte(input int idx);
      logic [7:0] b;
      b = SOH_BYTE;
      unique case (idx)
         0:       b = 8'h38;
         1:       b = CHAR_EQUAL;
         2:       b = 8'h46;
         3:       b = 8'h49;
         4:       b = 8'h58;
         5:       b = 8'h2e;
         6:       b = 8'h34;
         7:       b = 8'h2e;
         8:       b = 8'h34;
         default: b = SOH_BYTE;
      endcase
      return b;
   endfunction

endpackage

>>> hw/rtl/fsf_front.sv
// fsf_front: accepts stream bytes and registers their classification.
// Depends on fsf_pkg.
module fsf_front
   import fsf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_stream_byte,
   output logic       cls_valid,
   input  logic       cls_ready,
   output class_type  cls_data
);

   logic      valid_ff;
   logic      valid_in;
   class_type class_ff;
   class_type class_in;
   logic      load;

   assign load      = !valid_ff || cls_ready;
   assign req_stall = !load;
   assign valid_in  = load ? req_valid : valid_ff;

   always_comb begin
      for (int i = 0; i < BEGIN_LEN; i++) begin
         class_in.begin_hit[i] = (req_stream_byte == begin_byte(i));
      end
      class_in.len_tag_hit[0] = (req_stream_byte == CHAR_NINE);
      class_in.len_tag_hit[1] = (req_stream_byte == CHAR_EQUAL);
      class_in.sum_tag_hit[0] = (req_stream_byte == CHAR_ONE);
      class_in.sum_tag_hit[1] = (req_stream_byte == CHAR_ZERO);
      class_in.sum_tag_hit[2] = (req_stream_byte == CHAR_EQUAL);
      class_in.is_soh         = (req_stream_byte == SOH_BYTE);
      class_in.is_digit       = (req_stream_byte >= CHAR_ZERO) && (req_stream_byte <= CHAR_NINE);
      class_in.digit          = req_stream_byte[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         class_ff <= class_in;
      end
   end

   assign cls_valid = valid_ff;
   assign cls_data  = class_ff;

endmodule

>>> hw/rtl/fsf_queue.sv
// fsf_queue: short first-in first-out queue of classified bytes.
// Depends on fsf_pkg.
module fsf_queue
   import fsf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  class_type push_data,
   output logic      pop_valid,
   input  logic      pop_take,
   output class_type pop_data,
   output logic [QUEUE_AW:0] fill
);

   class_type           entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] head_ff;
   logic [QUEUE_AW-1:0] head_in;
   logic [QUEUE_AW-1:0] tail_ff;
   logic [QUEUE_AW-1:0] tail_in;
   logic [QUEUE_AW:0]   count_ff;
   logic [QUEUE_AW:0]   count_in;
   logic                push;
   logic                pop;

   assign push_ready = (count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_take;
   assign pop_data   = entry_ff[head_ff];
   assign fill       = count_ff;

   // Advance pointers with wrap at the queue depth.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop) begin
         head_in = (head_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QUEUE_AW'(1);
      end
      if (push) begin
         tail_in = (tail_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + QUEUE_AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/fsf_back.sv
// fsf_back: framing state machine and result register of the framer.
// Depends on fsf_pkg; fed by fsf_queue.
module fsf_back
   import fsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_max_body_bytes,
   input  logic        cls_valid,
   output logic        cls_take,
   input  class_type   cls_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [32:0] rsp_message_length,
   output logic [31:0] rsp_body_bytes,
   output logic [31:0] rsp_message_count
);

   localparam logic [2:0] PH_BEGIN   = 3'd0;
   localparam logic [2:0] PH_TAG     = 3'd1;
   localparam logic [2:0] PH_DIGITS  = 3'd2;
   localparam logic [2:0] PH_BODY    = 3'd3;
   localparam logic [2:0] PH_TRAILER = 3'd4;

   logic [2:0]       phase_ff,  phase_in;
   logic [POS_W-1:0] pos_ff,    pos_in;
   logic [31:0]      acc_ff,    acc_in;
   logic [31:0]      remain_ff, remain_in;
   logic [32:0]      bytes_ff,  bytes_in;
   logic [31:0]      total_ff,  total_in;
   logic             failed_ff, failed_in;
   logic [31:0]      max_ff;
   logic             rsp_valid_ff;
   logic [2:0]       status_ff;
   logic [32:0]      msg_len_ff;
   logic [31:0]      body_len_ff;
   logic [31:0]      count_ff;

   logic             take;
   logic             res_valid;
   logic [2:0]       res_status;
   logic [32:0]      res_msg_len;
   logic [31:0]      res_body_len;
   logic [31:0]      res_count;
   logic [32:0]      bytes_inc;
   logic [POS_W-1:0] pos_inc;
   logic [35:0]      acc_next;
   logic             begin_ok;
   logic             tag_ok;
   logic             sum_ok;

   assign csr_ready = 1'b1;
   assign take      = cls_valid && (!rsp_valid_ff || !rsp_stall);
   assign cls_take  = take;
   assign bytes_inc = bytes_ff + 33'd1;
   assign pos_inc   = pos_ff + POS_W'(1);
   assign acc_next  = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {32'd0, cls_data.digit};

   // Pick the match bit for the current place in each fixed string.
   always_comb begin
      begin_ok = 1'b0;
      for (int i = 0; i < BEGIN_LEN; i++) begin
         if (pos_ff == POS_W'(i)) begin
            begin_ok = cls_data.begin_hit[i];
         end
      end
      tag_ok = 1'b0;
      for (int i = 0; i < LENGTH_TAG_LEN; i++) begin
         if (pos_ff == POS_W'(i)) begin
            tag_ok = cls_data.len_tag_hit[i];
         end
      end
      sum_ok = 1'b1;
      for (int i = 0; i < SUM_TAG_LEN; i++) begin
         if (pos_ff == POS_W'(i)) begin
            sum_ok = cls_data.sum_tag_hit[i];
         end
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      remain_in    = remain_ff;
      bytes_in     = bytes_ff;
      total_in     = total_ff;
      failed_in    = failed_ff;
      res_valid    = 1'b0;
      res_status   = ST_OK;
      res_msg_len  = '0;
      res_body_len = '0;
      res_count    = total_ff;
      if (take && !failed_ff) begin
         bytes_in = bytes_inc;
         unique case (phase_ff)
            PH_TAG: begin
               if (!tag_ok) begin
                  res_valid  = 1'b1;
                  res_status = ST_NO_LEN_TAG;
               end else if (pos_inc == POS_W'(LENGTH_TAG_LEN)) begin
                  phase_in = PH_DIGITS;
                  pos_in   = '0;
                  acc_in   = '0;
               end else begin
                  pos_in = pos_inc;
               end
            end
            PH_DIGITS: begin
               if (cls_data.is_soh) begin
                  if (pos_ff == '0) begin
                     res_valid  = 1'b1;
                     res_status = ST_EMPTY_LEN;
                  end else begin
                     pos_in    = '0;
                     remain_in = acc_ff;
                     phase_in  = (acc_ff == '0) ? PH_TRAILER : PH_BODY;
                  end
               end else if (!cls_data.is_digit || pos_ff >= POS_W'(MAX_LENGTH_DIGITS)) begin
                  res_valid  = 1'b1;
                  res_status = ST_BAD_DIGITS;
               end else if (acc_next > {4'd0, max_ff}) begin
                  res_valid  = 1'b1;
                  res_status = ST_TOO_LARGE;
               end else begin
                  acc_in = acc_next[31:0];
                  pos_in = pos_inc;
               end
            end
            PH_BODY: begin
               remain_in = remain_ff - 32'd1;
               if (remain_ff == 32'd1) begin
                  phase_in = PH_TRAILER;
                  pos_in   = '0;
               end
            end
            PH_TRAILER: begin
               if (!sum_ok ||
                   (pos_ff >= POS_W'(TRAILER_BYTES - 1) && !cls_data.is_soh)) begin
                  res_valid  = 1'b1;
                  res_status = ST_NO_SUM;
               end else if (pos_inc >= POS_W'(TRAILER_BYTES)) begin
                  total_in     = total_ff + 32'd1;
                  res_valid    = 1'b1;
                  res_status   = ST_OK;
                  res_msg_len  = bytes_inc;
                  res_body_len = acc_ff;
                  res_count    = total_ff + 32'd1;
                  phase_in     = PH_BEGIN;
                  pos_in       = '0;
                  acc_in       = '0;
                  bytes_in     = '0;
               end else begin
                  pos_in = pos_inc;
               end
            end
            default: begin
               phase_in = PH_BEGIN;
               if (!begin_ok) begin
                  res_valid  = 1'b1;
                  res_status = ST_BAD_BEGIN;
               end else if (pos_inc == POS_W'(BEGIN_LEN)) begin
                  phase_in = PH_TAG;
                  pos_in   = '0;
               end else begin
                  pos_in = pos_inc;
               end
            end
         endcase
         if (res_valid && res_status != ST_OK) begin
            failed_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_BEGIN;
         pos_ff       <= '0;
         acc_ff       <= '0;
         remain_ff    <= '0;
         bytes_ff     <= '0;
         total_ff     <= '0;
         failed_ff    <= 1'b0;
         max_ff       <= MAX_BODY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         acc_ff    <= acc_in;
         remain_ff <= remain_in;
         bytes_ff  <= bytes_in;
         total_ff  <= total_in;
         failed_ff <= failed_in;
         if (csr_valid) begin
            max_ff <= csr_max_body_bytes;
         end
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_valid_ff <= res_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         status_ff   <= res_status;
         msg_len_ff  <= res_msg_len;
         body_len_ff <= res_body_len;
         count_ff    <= res_count;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_message_length = msg_len_ff;
   assign rsp_body_bytes     = body_len_ff;
   assign rsp_message_count  = count_ff;

endmodule

>>> hw/rtl/fix_stream_framer.sv
// fix_stream_framer: frames FIX 4.4 messages from a byte stream, one byte per cycle while req_stall is low.
// A byte is registered by the front end and queued before the back end acts on it; its result is then registered.
// The framing state machine takes a new byte whenever the result register is free or not stalled.
// Reset: synchronous, active high; clears all framing state, the queue and the valid flag of the result
// register, and loads the maximum body length with 65536. No clearing pass is needed.
// Depends on fsf_pkg, fsf_front, fsf_queue and fsf_back.
module fix_stream_framer
   import fsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_max_body_bytes,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [32:0] rsp_message_length,
   output logic [31:0] rsp_body_bytes,
   output logic [31:0] rsp_message_count
);

   // Front end to queue
   logic      front_valid;
   logic      front_ready;
   class_type front_class;

   // Queue to back end
   logic              queue_valid;
   logic              queue_take;
   class_type         queue_class;
   logic [QUEUE_AW:0] queue_fill;

   // Front end: take each byte transfer and register its classification
   // (matches against the fixed strings, SOH, digit value).
   fsf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .cls_valid       (front_valid),
      .cls_ready       (front_ready),
      .cls_data        (front_class)
   );

   // Decouple the two halves so a stalled result side does not stall
   // the input side at once.
   fsf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_class),
      .pop_valid  (queue_valid),
      .pop_take   (queue_take),
      .pop_data   (queue_class),
      .fill       (queue_fill)
   );

   // Back end: advance the framing state machine, hold sticky errors and
   // drive the result register.
   fsf_back u_back (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_max_body_bytes  (csr_max_body_bytes),
      .cls_valid           (queue_valid),
      .cls_take            (queue_take),
      .cls_data            (queue_class),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_message_length  (rsp_message_length),
      .rsp_body_bytes      (rsp_body_bytes),
      .rsp_message_count   (rsp_message_count)
   );

   // Error results carry no lengths.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_message_length == '0 && rsp_body_bytes == '0)
      else $error("error result with non-zero length");

   // A framed message is at least the fixed framing plus its body.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK |->
         {1'b0, rsp_message_length} >= {2'b00, rsp_body_bytes} + 34'(MIN_FRAME_BYTES))
      else $error("framed message shorter than its body and framing");

   // Errors are sticky: once an error result is transferred, nothing follows.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_status != ST_OK |=> !rsp_valid)
      else $error("result after a sticky error");

   // The queue never fills beyond its depth.
   assert property (@(posedge clock) disable iff (reset)
      queue_fill <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("queue overfilled");

endmodule

>>> verif/fix_stream_framer_tb.sv
`timescale 1ns / 1ps
// fix_stream_framer_tb: self-checking testbench for the FIX stream framer, with a
// frame tracker class that predicts every result from the accepted bytes.
// Depends on fsf_pkg and fix_stream_framer from hw/rtl.

import fsf_pkg::*;

typedef enum logic [2:0] {
   PARSE_BEGIN,
   PARSE_LEN_TAG,
   PARSE_DIGITS,
   PARSE_BODY,
   PARSE_TRAILER
} parse_phase_type;

typedef enum int {
   FAULT_NONE,
   FAULT_BEGIN,
   FAULT_TAG,
   FAULT_DIGIT,
   FAULT_EXTRA_DIGIT,
   FAULT_EMPTY,
   FAULT_SUM,
   FAULT_OVERSIZE
} fault_type;

typedef struct packed {
   logic [2:0]  status;
   logic [32:0] message_length;
   logic [31:0] body_bytes;
   logic [31:0] message_count;
} frame_outcome_type;

localparam logic [8*BEGIN_LEN-1:0] BEGIN_TEXT = {"8=FIX.4.4", SOH_BYTE};

function automatic logic [7:0] begin_char(input int idx);
   return BEGIN_TEXT[8*(BEGIN_LEN-1-idx) +: 8];
endfunction

class frame_tracker;
   logic [31:0]       max_body;
   parse_phase_type   phase;
   logic [31:0]       position;
   logic [35:0]       length_acc;
   logic [32:0]       msg_bytes;
   logic [31:0]       framed;
   bit                failed;
   frame_outcome_type pending_frames[$];
   int unsigned       errors;

   function new();
      max_body   = MAX_BODY_RESET;
      phase      = PARSE_BEGIN;
      position   = '0;
      length_acc = '0;
      msg_bytes  = '0;
      framed     = '0;
      failed     = 1'b0;
      errors     = 0;
   endfunction

   function void set_max_body(input logic [31:0] value);
      max_body = value;
   endfunction

   function int pending();
      return pending_frames.size();
   endfunction

   function void flag_error(input logic [2:0] code);
      frame_outcome_type o;
      failed           = 1'b1;
      o.status         = code;
      o.message_length = '0;
      o.body_bytes     = '0;
      o.message_count  = framed;
      pending_frames   = {pending_frames, o};
   endfunction

   function void take_byte(input logic [7:0] b);
      frame_outcome_type o;
      logic [7:0]        want;
      if (failed) return;
      msg_bytes = msg_bytes + 33'd1;
      case (phase)
         PARSE_LEN_TAG: begin
            want = (position == 0) ? CHAR_NINE : CHAR_EQUAL;
            if (b != want) begin
               flag_error(ST_NO_LEN_TAG);
            end else begin
               position = position + 1;
               if (position == LENGTH_TAG_LEN) begin
                  phase      = PARSE_DIGITS;
                  position   = '0;
                  length_acc = '0;
               end
            end
         end
         PARSE_DIGITS: begin
            if (b == SOH_BYTE) begin
               if (position == 0) begin
                  flag_error(ST_EMPTY_LEN);
               end else begin
                  position = '0;
                  phase    = (length_acc == 0) ? PARSE_TRAILER : PARSE_BODY;
               end
            end else if (b < CHAR_ZERO || b > CHAR_NINE || position >= MAX_LENGTH_DIGITS) begin
               flag_error(ST_BAD_DIGITS);
            end else begin
               length_acc = length_acc * 36'd10 + 36'(b - CHAR_ZERO);
               if (length_acc > {4'd0, max_body}) flag_error(ST_TOO_LARGE);
               else position = position + 1;
            end
         end
         PARSE_BODY: begin
            position = position + 1;
            if ({4'd0, position} >= length_acc) begin
               phase    = PARSE_TRAILER;
               position = '0;
            end
         end
         PARSE_TRAILER: begin
            want = (position == 0) ? CHAR_ONE : (position == 1) ? CHAR_ZERO : CHAR_EQUAL;
            if ((position < SUM_TAG_LEN && b != want) ||
                (position >= TRAILER_BYTES - 1 && b != SOH_BYTE)) begin
               flag_error(ST_NO_SUM);
            end else begin
               position = position + 1;
               if (position >= TRAILER_BYTES) begin
                  framed           = framed + 1;
                  o.status         = ST_OK;
                  o.message_length = msg_bytes;
                  o.body_bytes     = length_acc[31:0];
                  o.message_count  = framed;
                  pending_frames   = {pending_frames, o};
                  phase      = PARSE_BEGIN;
                  position   = '0;
                  length_acc = '0;
                  msg_bytes  = '0;
               end
            end
         end
         default: begin
            phase = PARSE_BEGIN;
            if (position >= BEGIN_LEN || b != begin_char(int'(position))) begin
               flag_error(ST_BAD_BEGIN);
            end else begin
               position = position + 1;
               if (position == BEGIN_LEN) begin
                  phase    = PARSE_LEN_TAG;
                  position = '0;
               end
            end
         end
      endcase
   endfunction

   function void compare_field(input string what, input logic [32:0] want,
                               input logic [32:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
         errors++;
      end
   endfunction

   function void match_frame(input logic [2:0] status, input logic [32:0] msg_len,
                             input logic [31:0] body_len, input logic [31:0] count);
      frame_outcome_type want;
      if (pending_frames.size() == 0) begin
         $display("%0t: result expected none, actual status %0d length %0d body %0d count %0d",
                  $time, status, msg_len, body_len, count);
         errors++;
      end else begin
         want = pending_frames.pop_front();
         compare_field("status", want.status, status);
         compare_field("message_length", want.message_length, msg_len);
         compare_field("body_bytes", want.body_bytes, body_len);
         compare_field("message_count", want.message_count, count);
      end
   endfunction
endclass

module fix_stream_framer_tb;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 8;      // lets bytes that cause no result leave the pipeline
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_BYTES     = 345;

   logic        clock               = 1'b0;
   logic        reset               = 1'b1;
   logic        csr_valid           = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_max_body_bytes  = '0;
   logic        req_valid           = 1'b0;
   logic        req_stall;
   logic [7:0]  req_stream_byte     = '0;
   logic        rsp_valid;
   logic        rsp_stall           = 1'b0;
   logic [2:0]  rsp_status;
   logic [32:0] rsp_message_length;
   logic [31:0] rsp_body_bytes;
   logic [31:0] rsp_message_count;

   frame_tracker tracker;
   int unsigned  cycle_count   = 0;
   int unsigned  sent_bytes    = 0;
   int unsigned  req_idle_pct  = 0;
   int unsigned  rsp_stall_pct = 0;
   logic         hold_off      = 1'b0;
   logic [31:0]  cur_max       = MAX_BODY_RESET;

   fix_stream_framer dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_max_body_bytes  (csr_max_body_bytes),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_stream_byte     (req_stream_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_message_length  (rsp_message_length),
      .rsp_body_bytes      (rsp_body_bytes),
      .rsp_message_count   (rsp_message_count)
   );

   // 8 ns period clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: abandon the run if the block stops making progress.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("fix_stream_framer: mismatch");
         $finish;
      end
   end

   // Result side back-pressure: a long hold-off when asked for, random stalls otherwise.
   always @(posedge clock) begin
      rsp_stall <= hold_off || ($urandom_range(99) < rsp_stall_pct);
   end

   // Sample both channels at the edge, before any driven value moves. Note the byte
   // transfer first so that the tracker never lags the block.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) tracker.take_byte(req_stream_byte);
         if (rsp_valid && !rsp_stall)
            tracker.match_frame(rsp_status, rsp_message_length, rsp_body_bytes,
                                rsp_message_count);
      end
   end

   // Offer one byte, idling first at the current rate, and hold it until the transfer.
   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= value;
      do @(posedge clock); while (req_stall);
      sent_bytes++;
   endtask

   // Drop valid and wait until every predicted result has arrived, then let the
   // pipeline empty of bytes that cause no result.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the maximum body length; only called while the block is idle.
   task automatic write_max_body(input logic [31:0] value);
      csr_valid          <= 1'b1;
      csr_max_body_bytes <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.set_max_body(value);
      cur_max = value;
   endtask

   // Build one message and stream it. width pads the BodyLength with leading zeros;
   // fault spoils one byte (or the digit count) so that the framer must flag it.
   task automatic send_frame(input logic [31:0] body_len, input int width,
                             input fault_type fault, input bit extremes);
      logic [7:0]  frame[$];
      logic [7:0]  digits[$];
      logic [7:0]  b;
      logic [31:0] v;
      int          digit_at, sum_at, k, pick;
      v = body_len;
      do begin
         digits.push_front(CHAR_ZERO + 8'(v % 10));
         v = v / 10;
      end while (v != 0);
      if (fault == FAULT_EXTRA_DIGIT) width = MAX_LENGTH_DIGITS + 1;
      while (digits.size() < width) digits.push_front(CHAR_ZERO);
      if (fault == FAULT_EMPTY) digits.delete();

      for (k = 0; k < BEGIN_LEN; k++) frame = {frame, begin_char(k)};
      frame = {frame, CHAR_NINE};
      frame = {frame, CHAR_EQUAL};
      digit_at = frame.size();
      foreach (digits[i]) frame = {frame, digits[i]};
      frame = {frame, SOH_BYTE};

      // Body content is never inspected: mix in SOH and the byte extremes.
      for (k = 0; k < body_len; k++) begin
         pick = $urandom_range(15);
         if (extremes) b = k[0] ? 8'hFF : 8'h00;
         else if (pick == 0) b = 8'h00;
         else if (pick == 1) b = 8'hFF;
         else if (pick == 2) b = SOH_BYTE;
         else b = 8'($urandom_range(255));
         frame = {frame, b};
      end

      sum_at = frame.size();
      frame = {frame, CHAR_ONE};
      frame = {frame, CHAR_ZERO};
      frame = {frame, CHAR_EQUAL};
      if (extremes) begin
         frame = {frame, 8'hFF};
         frame = {frame, 8'h00};
         frame = {frame, SOH_BYTE};
      end else begin
         repeat (3) frame = {frame, 8'($urandom_range(255))};
      end
      frame = {frame, SOH_BYTE};

      case (fault)
         FAULT_BEGIN: begin
            k = $urandom_range(BEGIN_LEN - 1);
            frame[k] ^= 8'h01 << $urandom_range(7);
         end
         FAULT_TAG: begin
            k = BEGIN_LEN + $urandom_range(LENGTH_TAG_LEN - 1);
            frame[k] ^= 8'h01 << $urandom_range(7);
         end
         FAULT_DIGIT: begin
            k = digit_at + $urandom_range(digits.size() - 1);
            do b = 8'($urandom_range(255));
            while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == SOH_BYTE);
            frame[k] = b;
         end
         FAULT_SUM: begin
            // Spoil one of the tag bytes or the closing SOH.
            k = $urandom_range(SUM_TAG_LEN);
            k = (k == SUM_TAG_LEN) ? sum_at + TRAILER_BYTES - 1 : sum_at + k;
            frame[k] ^= 8'h01 << $urandom_range(7);
         end
         default: ;
      endcase

      foreach (frame[i]) send_byte(frame[i]);
   endtask

   // Well-formed messages with random content until the byte budget is spent.
   // Most bodies are short; a few reach a few hundred bytes.
   task automatic run_frames(input int budget);
      int unsigned first;
      logic [31:0] len;
      int          pick, width;
      first = sent_bytes;
      while (sent_bytes - first < budget) begin
         pick = $urandom_range(99);
         if (pick < 15) len = 0;
         else if (pick < 20) len = $urandom_range(300);
         else len = $urandom_range(24);
         if (len > cur_max) len = $urandom_range(cur_max);
         width = ($urandom_range(3) == 0) ? $urandom_range(MAX_LENGTH_DIGITS, 1) : 1;
         send_frame(len, width, FAULT_NONE, 1'b0);
      end
      settle();
   endtask

   initial begin : stimulus
      fault_type   fault;
      logic [31:0] len;
      tracker = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty body with all ten digits as leading zeros at the reset maximum,
      // then a body exactly at the maximum carrying the byte extremes.
      send_frame(0, MAX_LENGTH_DIGITS, FAULT_NONE, 1'b0);
      settle();
      write_max_body(32'd2);
      send_frame(2, MAX_LENGTH_DIGITS, FAULT_NONE, 1'b1);
      settle();

      // Full-range maximum, no idling on either side.
      write_max_body(32'hFFFF_FFFF);
      req_idle_pct   = 0;
      rsp_stall_pct <= 0;
      run_frames(PHASE_BYTES);

      // Sparse sender.
      write_max_body($urandom_range(65535, 24));
      req_idle_pct   = 79;
      rsp_stall_pct <= 0;
      run_frames(PHASE_BYTES);

      // Maximum of zero: only empty bodies pass. Heavy receiver stalls.
      write_max_body(32'd0);
      req_idle_pct   = 0;
      rsp_stall_pct <= 79;
      run_frames(PHASE_BYTES);

      // Hold the receiver off while short messages keep coming, so the byte
      // queue fills and the block has to stall its input.
      req_idle_pct   = 0;
      rsp_stall_pct <= 0;
      fork
         begin
            hold_off <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off <= 1'b0;
         end
         begin
            repeat (16) send_frame(0, 1, FAULT_NONE, 1'b0);
            settle();
         end
      join

      // Light idling on both sides.
      write_max_body($urandom_range(32'hFFFF_FFFE, 24));
      req_idle_pct   = 19;
      rsp_stall_pct <= 19;
      run_frames(PHASE_BYTES);

      // Errors are sticky, so finish with one broken message of a random kind,
      // then noise and a clean message that must both be ignored.
      fault = fault_type'($urandom_range(FAULT_OVERSIZE, FAULT_BEGIN));
      if (fault == FAULT_OVERSIZE) begin
         write_max_body($urandom_range(40));
         len = cur_max + 1 + $urandom_range(20);
      end else begin
         len = $urandom_range(12);
      end
      send_frame(len, 1, fault, 1'b0);
      repeat (40) send_byte(8'($urandom_range(255)));
      send_frame(0, 1, FAULT_NONE, 1'b0);

      rsp_stall_pct <= 0;
      settle();
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("fix_stream_framer: match");
      end else begin
         $display("fix_stream_framer: mismatch");
      end
      $finish;
   end

endmodule
